// File: rtl/bafp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bafp_pkg;

    // Structure type codes
    localparam logic [7:0] AD_SHORT_NAME    = 8'h08;
    localparam logic [7:0] AD_COMPLETE_NAME = 8'h09;
    localparam logic [7:0] AD_SERVICE_DATA  = 8'h16;
    localparam logic [7:0] AD_MANUFACTURER  = 8'hFF;

    // 16-bit service UUID bytes, little-endian on air
    localparam logic [7:0] UUID_TEMP_LO     = 8'h6E;
    localparam logic [7:0] UUID_TEMP_HI     = 8'h2A;
    localparam logic [7:0] UUID_BATSVC_LO   = 8'h0F;
    localparam logic [7:0] UUID_BATSVC_HI   = 8'h18;
    localparam logic [7:0] UUID_BATLVL_LO   = 8'h19;
    localparam logic [7:0] UUID_BATLVL_HI   = 8'h2A;

    // Vendor frame codes
    localparam logic [7:0] VF_BATTERY       = 8'hF1;
    localparam logic [7:0] VF_VOLTAGE       = 8'hF2;
    localparam logic [7:0] VF_TEMPERATURE   = 8'h12;

    localparam logic [15:0] VENDOR_ID_RST   = 16'h0757;

    // Type byte plus the next five bytes of a structure
    localparam int SB_DEPTH = 6;

    typedef struct packed {
        logic [15:0] temperature_raw;
        logic        temperature_found;
        logic [7:0]  battery_level;
        logic        battery_found;
        logic [15:0] voltage_raw;
        logic        voltage_found;
        logic [4:0]  name_start;
        logic [4:0]  name_length;
        logic        name_found;
        logic        vendor_match;
        logic        sensor_like;
        logic        too_long;
    } t_result;

    typedef struct packed {
        logic        en;
        logic [7:0]  data;
        logic        last;
    } t_byte_xfer;

endpackage

`default_nettype wire

// File: rtl/bafp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module bafp_in_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire  [7:0]             i_adv_byte,
    input  wire                    i_last_byte,
    input  wire                    i_advance,
    output bafp_pkg::t_byte_xfer   o_xfer
);
    import bafp_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;

    // Take a new byte when the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_adv_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_xfer.en   = r_valid;
    assign o_xfer.data = r_data;
    assign o_xfer.last = r_last;

endmodule

`default_nettype wire

// File: rtl/bafp_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module bafp_walker #(
    parameter int MAX_PAYLOAD = 31
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_step,
    input  wire  bafp_pkg::t_byte_xfer i_xfer,
    input  wire  [15:0]            i_vendor_id,
    output bafp_pkg::t_result      o_result
);
    import bafp_pkg::*;

    localparam int OFS_W = $clog2(MAX_PAYLOAD + 1);
    localparam int SUM_W = OFS_W + 1;
    localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_PAYLOAD);

    // Payload walk state
    logic [OFS_W-1:0] r_offset, n_offset, u_offset;
    logic [OFS_W-1:0] r_start,  n_start,  u_start;
    logic [7:0]       r_len,    n_len,    u_len;
    logic [7:0]       r_sb [SB_DEPTH];
    logic [7:0]       n_sb [SB_DEPTH];
    logic [7:0]       u_sb [SB_DEPTH];
    logic             r_stopped, n_stopped, u_stopped;
    // Findings: flag plus value
    logic [16:0]      r_temp, n_temp, u_temp;
    logic [8:0]       r_batt, n_batt, u_batt;
    logic [16:0]      r_volt, n_volt, u_volt;
    logic [10:0]      r_name, n_name, u_name;
    logic [15:0]      r_manuf, n_manuf, u_manuf;
    logic             r_mseen, n_mseen, u_mseen;

    logic [OFS_W-1:0] w_rel;
    logic [2:0]       w_idx;
    logic [7:0]       w_cur_len;
    logic [SUM_W-1:0] w_name_pos;
    logic [7:0]       w_len_m1;
    logic             w_vm;

    assign w_rel      = r_offset - r_start;
    assign w_idx      = w_rel[2:0] - 3'd1;
    assign w_cur_len  = (w_rel == '0) ? i_xfer.data : r_len;
    assign w_name_pos = SUM_W'(r_start) + SUM_W'(2);
    assign w_len_m1   = w_cur_len - 8'd1;

    // Advance the walk by one byte and close a structure on its final byte; stop once the offset reaches MAX_PAYLOAD
    always_comb begin
        u_offset  = r_offset;
        u_start   = r_start;
        u_len     = r_len;
        u_sb      = r_sb;
        u_stopped = r_stopped;
        u_temp    = r_temp;
        u_batt    = r_batt;
        u_volt    = r_volt;
        u_name    = r_name;
        u_manuf   = r_manuf;
        u_mseen   = r_mseen;
        if (!r_stopped) begin
            if (r_offset >= MAX_OFS) begin
                u_stopped = 1'b1;
            end else begin
                if (w_rel == '0) begin
                    u_len = i_xfer.data;
                    for (int k = 0; k < SB_DEPTH; k++) begin
                        u_sb[k] = 8'h00;
                    end
                end else if (w_rel <= OFS_W'(SB_DEPTH)) begin
                    u_sb[w_idx] = i_xfer.data;
                end
                if (8'(w_rel) == w_cur_len) begin
                    if (w_cur_len > 8'd1 &&
                        (u_sb[0] == AD_SHORT_NAME || u_sb[0] == AD_COMPLETE_NAME)) begin
                        u_name = {1'b1, w_name_pos[4:0], w_len_m1[4:0]};
                    end else if (w_cur_len == 8'd5 && u_sb[0] == AD_SERVICE_DATA &&
                                 u_sb[1] == UUID_TEMP_LO && u_sb[2] == UUID_TEMP_HI) begin
                        u_temp = {1'b1, u_sb[4], u_sb[3]};
                    end else if (w_cur_len == 8'd4 && u_sb[0] == AD_SERVICE_DATA &&
                                 ((u_sb[1] == UUID_BATSVC_LO && u_sb[2] == UUID_BATSVC_HI) ||
                                  (u_sb[1] == UUID_BATLVL_LO && u_sb[2] == UUID_BATLVL_HI)))
                    begin
                        u_batt = {1'b1, u_sb[3]};
                    end
                    if (w_cur_len >= 8'd3 && u_sb[0] == AD_MANUFACTURER) begin
                        u_manuf = {u_sb[2], u_sb[1]};
                        u_mseen = 1'b1;
                        if ({u_sb[2], u_sb[1]} == i_vendor_id) begin
                            if (w_cur_len == 8'd5 && u_sb[3] == VF_BATTERY) begin
                                u_batt = {1'b1, u_sb[4]};
                            end else if (w_cur_len == 8'd6 && u_sb[3] == VF_VOLTAGE) begin
                                u_volt = {1'b1, u_sb[5], u_sb[4]};
                            end else if (w_cur_len == 8'd6 && u_sb[3] == VF_TEMPERATURE) begin
                                u_temp = {1'b1, u_sb[5], u_sb[4]};
                            end
                        end
                    end
                    u_start = r_offset + OFS_W'(1);
                end
                u_offset = r_offset + OFS_W'(1);
            end
        end
    end

    // Clear everything after the final byte of a payload
    always_comb begin
        n_offset  = u_offset;
        n_start   = u_start;
        n_len     = u_len;
        n_sb      = u_sb;
        n_stopped = u_stopped;
        n_temp    = u_temp;
        n_batt    = u_batt;
        n_volt    = u_volt;
        n_name    = u_name;
        n_manuf   = u_manuf;
        n_mseen   = u_mseen;
        if (i_xfer.last) begin
            n_offset  = '0;
            n_start   = '0;
            n_len     = '0;
            for (int k = 0; k < SB_DEPTH; k++) begin
                n_sb[k] = 8'h00;
            end
            n_stopped = 1'b0;
            n_temp    = '0;
            n_batt    = '0;
            n_volt    = '0;
            n_name    = '0;
            n_manuf   = '0;
            n_mseen   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_start   <= '0;
            r_len     <= '0;
            for (int k = 0; k < SB_DEPTH; k++) begin
                r_sb[k] <= 8'h00;
            end
            r_stopped <= 1'b0;
            r_temp    <= '0;
            r_batt    <= '0;
            r_volt    <= '0;
            r_name    <= '0;
            r_manuf   <= '0;
            r_mseen   <= 1'b0;
        end else if (i_step) begin
            r_offset  <= n_offset;
            r_start   <= n_start;
            r_len     <= n_len;
            r_sb      <= n_sb;
            r_stopped <= n_stopped;
            r_temp    <= n_temp;
            r_batt    <= n_batt;
            r_volt    <= n_volt;
            r_name    <= n_name;
            r_manuf   <= n_manuf;
            r_mseen   <= n_mseen;
        end
    end

    // Format the report from the state after this byte
    assign w_vm = u_mseen && (u_manuf == i_vendor_id);

    always_comb begin
        o_result = '0;
        if (u_stopped) begin
            o_result.too_long = 1'b1;
        end else begin
            o_result.temperature_raw   = u_temp[15:0];
            o_result.temperature_found = u_temp[16];
            o_result.battery_level     = u_batt[7:0];
            o_result.battery_found     = u_batt[8];
            o_result.voltage_raw       = u_volt[15:0];
            o_result.voltage_found     = u_volt[16];
            o_result.name_start        = u_name[9:5];
            o_result.name_length       = u_name[4:0];
            o_result.name_found        = u_name[10];
            o_result.vendor_match      = w_vm;
            o_result.sensor_like       = w_vm || (u_temp[16] && u_name[10]);
        end
    end

endmodule

`default_nettype wire

// File: rtl/bafp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module bafp_out_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  wire  bafp_pkg::t_result i_result,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic                   o_full_stall,
    output bafp_pkg::t_result      o_result
);
    import bafp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // A waiting result blocks only a new result
    assign o_full_stall = r_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/ble_adv_sensor_field_parser.sv
// Advertising payload field extractor. Bytes of one advertising payload enter
// one per cycle on the input channel, the final byte marked by i_last_byte; one
// result leaves for each final byte, via the byte register and the output
// register. Outside the stall below the block sustains one byte per clock: the
// byte register feeds combinational structure walking and the result lands in an
// output register, so bytes keep flowing while a result waits. The input stalls
// only when a payload's final byte reaches the walker while the previous result
// has not yet been taken. Payloads longer than MAX_PAYLOAD bytes report too_long
// alone. The vendor company id register may be written between payloads.
`timescale 1ns / 1ps
`default_nettype none

module ble_adv_sensor_field_parser #(
    parameter int MAX_PAYLOAD = 31
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_adv_byte,
    input  wire         i_last_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_temperature_raw,
    output logic        o_temperature_found,
    output logic [7:0]  o_battery_level,
    output logic        o_battery_found,
    output logic [15:0] o_voltage_raw,
    output logic        o_voltage_found,
    output logic [4:0]  o_name_start,
    output logic [4:0]  o_name_length,
    output logic        o_name_found,
    output logic        o_vendor_match,
    output logic        o_sensor_like,
    output logic        o_too_long
);
    import bafp_pkg::*;

    logic [15:0] r_vendor_id;
    t_byte_xfer  w_xfer;
    t_result     w_next_result;
    t_result     w_result;
    logic        w_full_stall;
    logic        w_advance;

    // Hold the vendor company id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor_id <= VENDOR_ID_RST;
        end else if (i_cfg_wr_en) begin
            r_vendor_id <= i_cfg_wr_data;
        end
    end

    // Drain the byte register unless its result has nowhere to go
    assign w_advance = !(w_xfer.last && w_full_stall);

    bafp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_adv_byte  (i_adv_byte),
        .i_last_byte (i_last_byte),
        .i_advance   (w_advance),
        .o_xfer      (w_xfer)
    );

    bafp_walker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_xfer.en && w_advance),
        .i_xfer      (w_xfer),
        .i_vendor_id (r_vendor_id),
        .o_result    (w_next_result)
    );

    bafp_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_xfer.en && w_xfer.last && w_advance),
        .i_result     (w_next_result),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_full_stall (w_full_stall),
        .o_result     (w_result)
    );

    assign o_temperature_raw   = w_result.temperature_raw;
    assign o_temperature_found = w_result.temperature_found;
    assign o_battery_level     = w_result.battery_level;
    assign o_battery_found     = w_result.battery_found;
    assign o_voltage_raw       = w_result.voltage_raw;
    assign o_voltage_found     = w_result.voltage_found;
    assign o_name_start        = w_result.name_start;
    assign o_name_length       = w_result.name_length;
    assign o_name_found        = w_result.name_found;
    assign o_vendor_match      = w_result.vendor_match;
    assign o_sensor_like       = w_result.sensor_like;
    assign o_too_long          = w_result.too_long;

    // An overlong payload reports nothing else
    a_too_long_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_long |-> !o_temperature_found && !o_battery_found &&
            !o_voltage_found && !o_name_found && !o_vendor_match && !o_sensor_like &&
            o_temperature_raw == 16'h0000 && o_name_start == 5'd0)
        else $error("too_long result carries other fields");

    // Sensor classification follows the reported flags
    a_sensor_like: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sensor_like == (o_vendor_match || (o_temperature_found && o_name_found)))
        else $error("sensor_like inconsistent with flags");

    // A value not found reads as zero
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_found || o_temperature_raw == 16'h0000) &&
            (o_battery_found || o_battery_level == 8'h00) &&
            (o_voltage_found || o_voltage_raw == 16'h0000))
        else $error("value reported without its found flag");

    // A final byte stuck in the byte register means a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer.en && !w_advance |-> o_valid && !i_ready)
        else $error("walker stalled without a waiting result");

endmodule

`default_nettype wire
